// ----- rtl/core/lwsc_pkg.sv -----
// shared constants, types and codes of the sector cache tag engine
`timescale 1ns / 1ps

package lwsc_pkg;

	localparam int NUM_SLOTS = 256;
	localparam int SLOT_W    = $clog2(NUM_SLOTS);
	localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
	localparam int SECTOR_W  = 17;
	localparam int UNIT_W    = 2;
	localparam int KEY_HI_W  = 3;
	localparam int TAG_W     = KEY_HI_W + SECTOR_W;
	localparam int AGE_W     = 32;
	localparam int OSLOT_W   = 8;

	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_FLUSH  = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESOLVE
	} state_t;

	// one slot as it comes out of the store during a scan
	typedef struct packed {
		logic              vld;
		logic [SLOT_W-1:0] idx;
		logic              valid;
		logic              dirty;
		logic [TAG_W-1:0]  tag;
		logic [AGE_W-1:0]  age;
	} rd_data_t;

	// state update of one slot at the end of a request
	typedef struct packed {
		logic              tag_we;
		logic              age_we;
		logic              bits_we;
		logic [SLOT_W-1:0] addr;
		logic [TAG_W-1:0]  tag;
		logic [AGE_W-1:0]  age;
		logic              valid;
		logic              dirty;
	} st_wr_t;

	// what the scan found over all slots
	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] found_idx;
		logic [TAG_W-1:0]  found_tag;
		logic              found_dirty;
		logic              more;
		logic              free;
		logic [SLOT_W-1:0] free_idx;
		logic [SLOT_W-1:0] vict_idx;
		logic [TAG_W-1:0]  vict_tag;
		logic              vict_dirty;
	} scan_res_t;

endpackage

// ----- rtl/core/lru_writeback_sector_cache_tags.sv -----
// top level of the fully associative write-back sector cache tag engine
// a request scans every slot, then resolves and registers its result along with the done strobe
// no new request is taken while busy, since the single-port tag/age memories serve the scan
// busy is high from the accepting edge until the result is registered; done pulses one cycle
// reset clears all valid and dirty bits, the age counter and the sequencer; no clearing pass
// results hold until the next request resolves; the receiver cannot stall them
`timescale 1ns / 1ps

module lru_writeback_sector_cache_tags (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           cmd,
	input  logic                           dev_type,
	input  logic [lwsc_pkg::UNIT_W-1:0]    unit,
	input  logic [lwsc_pkg::SECTOR_W-1:0]  sector,
	input  logic                           for_write,
	input  logic                           backing_present,
	output logic                           done,
	output logic                           hit,
	output logic [lwsc_pkg::OSLOT_W-1:0]   slot,
	output logic                           fill_needed,
	output logic                           miss_error,
	output logic                           wb_valid,
	output logic                           wb_dev_type,
	output logic [lwsc_pkg::UNIT_W-1:0]    wb_unit,
	output logic [lwsc_pkg::SECTOR_W-1:0]  wb_sector,
	output logic [lwsc_pkg::OSLOT_W-1:0]   wb_slot,
	output logic                           more_pending
);

	lwsc_pkg::state_t state_q, state_d;

	logic [lwsc_pkg::CNT_W-1:0] cnt_q;
	logic [lwsc_pkg::AGE_W-1:0] age_cnt_q;

	// latched request
	logic                       cmd_q;
	logic [lwsc_pkg::TAG_W-1:0] key_q;
	logic                       wr_q;
	logic                       present_q;

	logic accept;
	logic scan_end;
	logic rd_en;
	logic resolve;

	lwsc_pkg::rd_data_t  rd_data;
	lwsc_pkg::scan_res_t res;
	lwsc_pkg::st_wr_t    st_wr;

	// result computed in the resolve cycle
	logic                          r_hit;
	logic [lwsc_pkg::SLOT_W-1:0]   r_slot;
	logic                          r_fill;
	logic                          r_err;
	logic                          r_wb;
	logic [lwsc_pkg::TAG_W-1:0]    r_wb_tag;
	logic [lwsc_pkg::SLOT_W-1:0]   r_wb_slot;
	logic                          r_more;
	logic [lwsc_pkg::AGE_W-1:0]    r_age_cnt;
	logic                          full;
	logic [lwsc_pkg::SLOT_W-1:0]   tgt;

	// output registers
	logic                           done_q;
	logic                           hit_q;
	logic [lwsc_pkg::OSLOT_W-1:0]   slot_q;
	logic                           fill_q;
	logic                           err_q;
	logic                           wb_q;
	logic                           wb_dev_q;
	logic [lwsc_pkg::UNIT_W-1:0]    wb_unit_q;
	logic [lwsc_pkg::SECTOR_W-1:0]  wb_sector_q;
	logic [lwsc_pkg::OSLOT_W-1:0]   wb_slot_q;
	logic                           more_q;

	assign scan_end = (cnt_q == lwsc_pkg::CNT_W'(lwsc_pkg::NUM_SLOTS));

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			lwsc_pkg::ST_IDLE: begin
				if (start) begin
					state_d = lwsc_pkg::ST_SCAN;
				end
			end
			lwsc_pkg::ST_SCAN: begin
				// last slot data is consumed in the cycle the address counter reaches the end
				if (scan_end) begin
					state_d = lwsc_pkg::ST_RESOLVE;
				end
			end
			lwsc_pkg::ST_RESOLVE: begin
				state_d = lwsc_pkg::ST_IDLE;
			end
			default: begin
				state_d = lwsc_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer: outputs
	always_comb begin
		busy    = 1'b1;
		rd_en   = 1'b0;
		resolve = 1'b0;
		case (state_q)
			lwsc_pkg::ST_IDLE: begin
				busy = 1'b0;
			end
			lwsc_pkg::ST_SCAN: begin
				rd_en = !scan_end;
			end
			lwsc_pkg::ST_RESOLVE: begin
				resolve = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= lwsc_pkg::ST_IDLE;
			cnt_q     <= '0;
			age_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= resolve;
			if (accept) begin
				cnt_q <= '0;
			end else if (rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (resolve) begin
				age_cnt_q <= r_age_cnt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= cmd;
			key_q     <= {dev_type, unit, sector};
			wr_q      <= for_write;
			present_q <= backing_present;
		end
	end

	lwsc_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (cnt_q[lwsc_pkg::SLOT_W-1:0]),
		.rd_data (rd_data),
		.wr      (st_wr)
	);

	lwsc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (accept),
		.cmd     (cmd_q),
		.key     (key_q),
		.rd_data (rd_data),
		.res     (res)
	);

	// resolve: decide the outcome from the scan and update at most one slot
	always_comb begin
		r_hit     = 1'b0;
		r_slot    = '0;
		r_fill    = 1'b0;
		r_err     = 1'b0;
		r_wb      = 1'b0;
		r_wb_tag  = '0;
		r_wb_slot = '0;
		r_more    = 1'b0;
		r_age_cnt = age_cnt_q;
		full      = !res.free;
		tgt       = full ? res.vict_idx : res.free_idx;

		st_wr         = '0;
		st_wr.tag     = key_q;

		if (cmd_q == lwsc_pkg::CMD_FLUSH) begin
			r_more = res.more;
			if (res.found) begin
				// write back the lowest dirty slot of the unit and clean it
				r_wb          = 1'b1;
				r_wb_tag      = res.found_tag;
				r_wb_slot     = res.found_idx;
				st_wr.bits_we = resolve;
				st_wr.addr    = res.found_idx;
				st_wr.valid   = 1'b1;
				st_wr.dirty   = 1'b0;
			end
		end else if (res.found) begin
			// hit: refresh age, writes mark dirty
			r_hit         = 1'b1;
			r_slot        = res.found_idx;
			r_age_cnt     = age_cnt_q + 1'b1;
			st_wr.age_we  = resolve;
			st_wr.bits_we = resolve;
			st_wr.addr    = res.found_idx;
			st_wr.age     = r_age_cnt;
			st_wr.valid   = 1'b1;
			st_wr.dirty   = res.found_dirty || wr_q;
		end else begin
			// miss: a full cache evicts the oldest entry first, even if the fill then fails
			if (full && res.vict_dirty) begin
				r_wb      = 1'b1;
				r_wb_tag  = res.vict_tag;
				r_wb_slot = res.vict_idx;
			end
			st_wr.addr = tgt;
			if (!present_q) begin
				r_err         = 1'b1;
				st_wr.bits_we = resolve && full;
				st_wr.valid   = 1'b0;
				st_wr.dirty   = 1'b0;
			end else begin
				r_fill        = 1'b1;
				r_slot        = tgt;
				r_age_cnt     = age_cnt_q + 2'd2;
				st_wr.tag_we  = resolve;
				st_wr.age_we  = resolve;
				st_wr.bits_we = resolve;
				st_wr.age     = r_age_cnt;
				st_wr.valid   = 1'b1;
				st_wr.dirty   = wr_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (resolve) begin
			hit_q       <= r_hit;
			slot_q      <= lwsc_pkg::OSLOT_W'(r_slot);
			fill_q      <= r_fill;
			err_q       <= r_err;
			wb_q        <= r_wb;
			wb_dev_q    <= r_wb_tag[lwsc_pkg::TAG_W-1];
			wb_unit_q   <= r_wb_tag[lwsc_pkg::SECTOR_W +: lwsc_pkg::UNIT_W];
			wb_sector_q <= r_wb_tag[lwsc_pkg::SECTOR_W-1:0];
			wb_slot_q   <= lwsc_pkg::OSLOT_W'(r_wb_slot);
			more_q      <= r_more;
		end
	end

	assign done         = done_q;
	assign hit          = hit_q;
	assign slot         = slot_q;
	assign fill_needed  = fill_q;
	assign miss_error   = err_q;
	assign wb_valid     = wb_q;
	assign wb_dev_type  = wb_dev_q;
	assign wb_unit      = wb_unit_q;
	assign wb_sector    = wb_sector_q;
	assign wb_slot      = wb_slot_q;
	assign more_pending = more_q;

endmodule

// ----- rtl/core/lwsc_store.sv -----
// slot state: tag and age memories plus valid and dirty bits
`timescale 1ns / 1ps

module lwsc_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                rd_en,
	input  logic [lwsc_pkg::SLOT_W-1:0]         rd_addr,
	output lwsc_pkg::rd_data_t                  rd_data,
	input  lwsc_pkg::st_wr_t                    wr
);

	logic [lwsc_pkg::TAG_W-1:0] tag_mem [lwsc_pkg::NUM_SLOTS];
	logic [lwsc_pkg::AGE_W-1:0] age_mem [lwsc_pkg::NUM_SLOTS];
	logic [lwsc_pkg::NUM_SLOTS-1:0] valid_q;
	logic [lwsc_pkg::NUM_SLOTS-1:0] dirty_q;

	logic                        rd_vld_s1;
	logic [lwsc_pkg::SLOT_W-1:0] rd_idx_s1;
	logic                        rd_valid_s1;
	logic                        rd_dirty_s1;
	logic [lwsc_pkg::TAG_W-1:0]  rd_tag_s1;
	logic [lwsc_pkg::AGE_W-1:0]  rd_age_s1;

	always_ff @(posedge clk) begin
		if (wr.tag_we) begin
			tag_mem[wr.addr] <= wr.tag;
		end
		if (wr.age_we) begin
			age_mem[wr.addr] <= wr.age;
		end
		if (rd_en) begin
			rd_tag_s1 <= tag_mem[rd_addr];
			rd_age_s1 <= age_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			dirty_q   <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (wr.bits_we) begin
				valid_q[wr.addr] <= wr.valid;
				dirty_q[wr.addr] <= wr.dirty;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_idx_s1   <= rd_addr;
			rd_valid_s1 <= valid_q[rd_addr];
			rd_dirty_s1 <= dirty_q[rd_addr];
		end
	end

	assign rd_data.vld   = rd_vld_s1;
	assign rd_data.idx   = rd_idx_s1;
	assign rd_data.valid = rd_valid_s1;
	assign rd_data.dirty = rd_dirty_s1;
	assign rd_data.tag   = rd_tag_s1;
	assign rd_data.age   = rd_age_s1;

endmodule

// ----- rtl/core/lwsc_scan.sv -----
// shared compare unit: one slot per cycle for hit, free, victim and flush search
`timescale 1ns / 1ps

module lwsc_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        clear,
	input  logic                        cmd,
	input  logic [lwsc_pkg::TAG_W-1:0]  key,
	input  lwsc_pkg::rd_data_t          rd_data,
	output lwsc_pkg::scan_res_t         res
);

	logic                        found_q;
	logic [lwsc_pkg::SLOT_W-1:0] found_idx_q;
	logic [lwsc_pkg::TAG_W-1:0]  found_tag_q;
	logic                        found_dirty_q;
	logic                        more_q;
	logic                        free_q;
	logic [lwsc_pkg::SLOT_W-1:0] free_idx_q;
	logic [lwsc_pkg::SLOT_W-1:0] vict_idx_q;
	logic [lwsc_pkg::TAG_W-1:0]  vict_tag_q;
	logic                        vict_dirty_q;
	logic [lwsc_pkg::AGE_W-1:0]  vict_age_q;

	logic match;
	logic take_vict;

	always_comb begin
		if (cmd == lwsc_pkg::CMD_FLUSH) begin
			match = rd_data.valid && rd_data.dirty &&
				(rd_data.tag[lwsc_pkg::TAG_W-1 -: lwsc_pkg::KEY_HI_W] ==
				 key[lwsc_pkg::TAG_W-1 -: lwsc_pkg::KEY_HI_W]);
		end else begin
			match = rd_data.valid && (rd_data.tag == key);
		end
		// strict less keeps ties on the lower slot
		take_vict = (rd_data.idx == '0) || (rd_data.age < vict_age_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			more_q  <= 1'b0;
			free_q  <= 1'b0;
		end else if (clear) begin
			found_q <= 1'b0;
			more_q  <= 1'b0;
			free_q  <= 1'b0;
		end else if (rd_data.vld) begin
			if (match) begin
				found_q <= 1'b1;
				if (found_q) begin
					more_q <= 1'b1;
				end
			end
			if (!rd_data.valid) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_data.vld) begin
			if (match && !found_q) begin
				found_idx_q   <= rd_data.idx;
				found_tag_q   <= rd_data.tag;
				found_dirty_q <= rd_data.dirty;
			end
			if (!rd_data.valid && !free_q) begin
				free_idx_q <= rd_data.idx;
			end
			if (take_vict) begin
				vict_idx_q   <= rd_data.idx;
				vict_tag_q   <= rd_data.tag;
				vict_dirty_q <= rd_data.dirty;
				vict_age_q   <= rd_data.age;
			end
		end
	end

	assign res.found       = found_q;
	assign res.found_idx   = found_idx_q;
	assign res.found_tag   = found_tag_q;
	assign res.found_dirty = found_dirty_q;
	assign res.more        = more_q;
	assign res.free        = free_q;
	assign res.free_idx    = free_idx_q;
	assign res.vict_idx    = vict_idx_q;
	assign res.vict_tag    = vict_tag_q;
	assign res.vict_dirty  = vict_dirty_q;

endmodule
